/* sv/hsvpg_pkg.sv */
// Shared constants, payload types and arithmetic helpers of the HSV plane pixel generator.
`default_nettype none

package hsvpg_pkg;

   // Image geometry; both sizes are powers of two.
   localparam int IMAGE_WIDTH  = 512;
   localparam int IMAGE_HEIGHT = 512;
   localparam int SCREEN_EDGE  = 512;
   localparam int W_LOG        = $clog2(IMAGE_WIDTH);
   localparam int H_LOG        = $clog2(IMAGE_HEIGHT);

   // Field widths.
   localparam int ROW_W      = 9;
   localparam int COL_W      = 9;
   localparam int POS_W      = 10;
   localparam int LVL_W      = 8;
   localparam int MODE_W     = 2;
   localparam int HUE_DEG_W  = 9;
   localparam int PCT_W      = 7;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 9;

   // Q0.16 fractions, one extra bit so that 1.0 fits.
   localparam int FRAC_BITS = 16;
   localparam int FRAC_W    = FRAC_BITS + 1;
   localparam logic [FRAC_W-1:0] ONE_Q = FRAC_W'(1 << FRAC_BITS);

   // Hue in units of 1/IMAGE_WIDTH degree; one sector spans SPAN units.
   localparam int HUE_W      = HUE_DEG_W + W_LOG;
   localparam int HUE_SCALE  = 360;
   localparam int SECTOR_DEG = 60;
   localparam int SPAN       = SECTOR_DEG * IMAGE_WIDTH;
   localparam int SPAN_W     = $clog2(SPAN + 1);
   localparam int SECTORS    = 6;

   // SPAN = DIV_ODD * 2^SPAN_SHIFT; the odd part is divided by reciprocal.
   localparam int DIV_ODD       = 15;
   localparam int SPAN_SHIFT    = W_LOG + 2;
   localparam int PROD_W        = FRAC_W + SPAN_W;
   localparam int QUO_W         = PROD_W - SPAN_SHIFT;
   localparam int DIV15_MUL     = 4369;
   localparam int DIV15_MUL_W   = 13;
   localparam int DIV15_SHIFT   = 16;
   localparam int MUL_W         = QUO_W + DIV15_MUL_W;
   localparam int DIV15_REM_MAX = 3 * DIV_ODD;

   // Percent to Q0.16: p*655 + floor(p*9/25), p/25 by reciprocal 1311/2^15.
   localparam int PCT_FULL      = 100;
   localparam int PCT_WHOLE_MUL = 655;
   localparam int PCT_FRAC_MUL  = 9;
   localparam int DIV25_MUL     = 1311;
   localparam int DIV25_SHIFT   = 15;
   localparam int PCT_PART_W    = 21;

   localparam int LVL_MAX   = 255;
   localparam int LVL_PROD_W = FRAC_W + LVL_W;

   // Plane modes.
   localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FIX_HUE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FIX_SAT = 2'd2;
   localparam logic [MODE_W-1:0] MODE_FIX_VAL = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_MODE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HUE        = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SAT        = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VAL        = 4'd3;

   // Hue sectors.
   localparam int SEC_W = 3;
   localparam logic [SEC_W-1:0] SEC_R_Y  = 3'd0;
   localparam logic [SEC_W-1:0] SEC_Y_G  = 3'd1;
   localparam logic [SEC_W-1:0] SEC_G_C  = 3'd2;
   localparam logic [SEC_W-1:0] SEC_C_B  = 3'd3;
   localparam logic [SEC_W-1:0] SEC_B_M  = 3'd4;
   localparam logic [SEC_W-1:0] SEC_M_R  = 3'd5;
   localparam logic [SEC_W-1:0] SEC_GREY = 3'd6;

   typedef struct packed {
      logic [MODE_W-1:0]    mode;
      logic [HUE_DEG_W-1:0] hue;
      logic [FRAC_W-1:0]    sat_q;
      logic [FRAC_W-1:0]    val_q;
   } cfg_type;

   typedef struct packed {
      logic [FRAC_W-1:0] vq;
      logic [FRAC_W-1:0] sq;
      logic [HUE_W-1:0]  hue;
      logic [POS_W-1:0]  sx;
      logic [POS_W-1:0]  sy;
      logic              vis;
   } coord_type;

   typedef struct packed {
      logic [FRAC_W-1:0] vq;
      logic [FRAC_W-1:0] c;
      logic [SPAN_W-1:0] w;
      logic [SEC_W-1:0]  sector;
      logic [POS_W-1:0]  sx;
      logic [POS_W-1:0]  sy;
      logic              vis;
   } chroma_type;

   typedef struct packed {
      logic [PROD_W-1:0] prod;
      logic [FRAC_W-1:0] c;
      logic [FRAC_W-1:0] m;
      logic [SEC_W-1:0]  sector;
      logic [POS_W-1:0]  sx;
      logic [POS_W-1:0]  sy;
      logic              vis;
   } prod_type;

   typedef struct packed {
      logic [QUO_W-1:0]  n;
      logic [MUL_W-1:0]  mul;
      logic [FRAC_W-1:0] c;
      logic [FRAC_W-1:0] m;
      logic [SEC_W-1:0]  sector;
      logic [POS_W-1:0]  sx;
      logic [POS_W-1:0]  sy;
      logic              vis;
   } quo_type;

   typedef struct packed {
      logic [FRAC_W-1:0] c;
      logic [FRAC_W-1:0] x;
      logic [FRAC_W-1:0] m;
      logic [SEC_W-1:0]  sector;
      logic [POS_W-1:0]  sx;
      logic [POS_W-1:0]  sy;
      logic              vis;
   } mix_type;

   // Coordinate to fraction of the image size, saturated at 1.0.
   function automatic logic [FRAC_W-1:0] row_frac(input logic [ROW_W-1:0] v);
      logic [FRAC_W-1:0] f;
      f = FRAC_W'(v) << (FRAC_BITS - H_LOG);
      if (32'(v) >= IMAGE_HEIGHT) begin
         f = ONE_Q;
      end
      return f;
   endfunction

   function automatic logic [FRAC_W-1:0] col_frac(input logic [COL_W-1:0] v);
      logic [FRAC_W-1:0] f;
      f = FRAC_W'(v) << (FRAC_BITS - W_LOG);
      if (32'(v) >= IMAGE_WIDTH) begin
         f = ONE_Q;
      end
      return f;
   endfunction

   // Percent to fraction, saturated at 1.0.
   function automatic logic [FRAC_W-1:0] pct_frac(input logic [PCT_W-1:0] p);
      logic [FRAC_W-1:0]     whole;
      logic [PCT_PART_W-1:0] part;
      whole = FRAC_W'(p) * FRAC_W'(PCT_WHOLE_MUL);
      part  = (PCT_PART_W'(p) * PCT_PART_W'(PCT_FRAC_MUL)) * PCT_PART_W'(DIV25_MUL);
      if (p >= PCT_W'(PCT_FULL)) begin
         return ONE_Q;
      end
      return whole + FRAC_W'(part >> DIV25_SHIFT);
   endfunction

   // Fraction to an 8-bit level: floor(v*255/65536), saturated.
   function automatic logic [LVL_W-1:0] to_level(input logic [FRAC_W-1:0] v);
      logic [LVL_PROD_W-1:0] prod;
      logic [LVL_W:0]        lvl;
      prod = LVL_PROD_W'(v) * LVL_PROD_W'(LVL_MAX);
      lvl  = prod[FRAC_BITS +: (LVL_W + 1)];
      if (lvl > (LVL_W + 1)'(LVL_MAX)) begin
         return LVL_W'(LVL_MAX);
      end
      return lvl[LVL_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* sv/hsvpg_ifs.sv */
// Handshake channel interfaces: pixel requests, pixel responses and register writes.
`default_nettype none

interface hsvpg_req_if;
   logic                           valid;
   logic                           ready;
   logic [hsvpg_pkg::ROW_W-1:0]    row_index;
   logic [hsvpg_pkg::COL_W-1:0]    column_index;

   modport source (output valid, output row_index, output column_index, input ready);
   modport sink   (input valid, input row_index, input column_index, output ready);
endinterface

interface hsvpg_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [hsvpg_pkg::POS_W-1:0]    screen_x;
   logic [hsvpg_pkg::POS_W-1:0]    screen_y;
   logic [hsvpg_pkg::LVL_W-1:0]    red_level;
   logic [hsvpg_pkg::LVL_W-1:0]    green_level;
   logic [hsvpg_pkg::LVL_W-1:0]    blue_level;
   logic                           visible;

   modport source (output valid, output screen_x, output screen_y, output red_level,
                   output green_level, output blue_level, output visible, input ready);
   modport sink   (input valid, input screen_x, input screen_y, input red_level,
                   input green_level, input blue_level, input visible, output ready);
endinterface

interface hsvpg_csr_if;
   logic                              valid;
   logic                              ready;
   logic [hsvpg_pkg::CSR_IDX_W-1:0]   index;
   logic [hsvpg_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/hsvpg_csr.sv */
// Configuration registers and their conversion to plane fractions.
`default_nettype none

module hsvpg_csr (
   input  logic               clock,
   input  logic               reset,
   hsvpg_csr_if.sink          csr_ch,
   output hsvpg_pkg::cfg_type cfg
);
   import hsvpg_pkg::*;

   logic [MODE_W-1:0]    mode_ff;
   logic [HUE_DEG_W-1:0] hue_ff;
   logic [PCT_W-1:0]     sat_ff;
   logic [PCT_W-1:0]     val_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_FIX_HUE;
         hue_ff  <= '0;
         sat_ff  <= '0;
         val_ff  <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_PLANE_MODE: mode_ff <= csr_ch.data[MODE_W-1:0];
            REG_HUE:        hue_ff  <= csr_ch.data[HUE_DEG_W-1:0];
            REG_SAT:        sat_ff  <= csr_ch.data[PCT_W-1:0];
            REG_VAL:        val_ff  <= csr_ch.data[PCT_W-1:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   assign cfg.mode  = mode_ff;
   assign cfg.hue   = hue_ff;
   assign cfg.sat_q = pct_frac(sat_ff);
   assign cfg.val_q = pct_frac(val_ff);

endmodule

`default_nettype wire

/* sv/hsvpg_front.sv */
// Front pipeline: plane decode, chroma and hue sector, then chroma-by-weight product.
`default_nettype none

module hsvpg_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [hsvpg_pkg::ROW_W-1:0] in_row,
   input  logic [hsvpg_pkg::COL_W-1:0] in_col,
   input  hsvpg_pkg::cfg_type        cfg,
   output logic                      out_valid,
   input  logic                      out_ready,
   output hsvpg_pkg::prod_type       out_data
);
   import hsvpg_pkg::*;

   localparam logic [POS_W-1:0] EDGE_POS = POS_W'(SCREEN_EDGE);

   coord_type  s1_in, s1_ff;
   chroma_type s2_in, s2_ff;
   prod_type   s3_in, s3_ff;
   logic       s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic       s1_rdy, s2_rdy, s3_rdy;

   logic [2*FRAC_W-1:0] vs_prod;
   logic [HUE_W-1:0]    hue_fold;

   assign s3_rdy   = !s3_vld_ff || out_ready;
   assign s2_rdy   = !s2_vld_ff || s3_rdy;
   assign s1_rdy   = !s1_vld_ff || s2_rdy;
   assign in_ready = s1_rdy;

   // Stage 1: pick the plane.
   always_comb begin
      s1_in = '0;
      unique case (cfg.mode)
         MODE_FIX_HUE: begin
            s1_in.vq  = row_frac(in_row);
            s1_in.sq  = col_frac(in_col);
            s1_in.hue = HUE_W'(cfg.hue) << W_LOG;
            s1_in.sx  = POS_W'(in_row);
            s1_in.sy  = EDGE_POS - POS_W'(in_col);
         end
         MODE_FIX_SAT: begin
            s1_in.vq  = row_frac(in_row);
            s1_in.sq  = cfg.sat_q;
            s1_in.hue = HUE_W'(in_col) * HUE_W'(HUE_SCALE);
            s1_in.sx  = EDGE_POS - POS_W'(in_col);
            s1_in.sy  = EDGE_POS - POS_W'(in_row);
         end
         MODE_FIX_VAL: begin
            s1_in.vq  = cfg.val_q;
            s1_in.sq  = row_frac(in_row);
            s1_in.hue = HUE_W'(in_col) * HUE_W'(HUE_SCALE);
            s1_in.sx  = EDGE_POS - POS_W'(in_col);
            s1_in.sy  = EDGE_POS - POS_W'(in_row);
         end
         default: begin
            // no plane: zero fractions and position give an all-zero result
         end
      endcase
      s1_in.vis = (cfg.mode != MODE_NONE) && (32'(s1_in.sx) < IMAGE_WIDTH) &&
                  (32'(s1_in.sy) < IMAGE_HEIGHT);
   end

   // Stage 2: chroma, weight within the sector and sector code.
   always_comb begin
      vs_prod = (2*FRAC_W)'(s1_ff.vq) * (2*FRAC_W)'(s1_ff.sq);
      priority if (s1_ff.hue >= HUE_W'(6*SPAN)) begin
         hue_fold = s1_ff.hue - HUE_W'(6*SPAN);
      end else if (s1_ff.hue >= HUE_W'(4*SPAN)) begin
         hue_fold = s1_ff.hue - HUE_W'(4*SPAN);
      end else if (s1_ff.hue >= HUE_W'(2*SPAN)) begin
         hue_fold = s1_ff.hue - HUE_W'(2*SPAN);
      end else begin
         hue_fold = s1_ff.hue;
      end

      s2_in.vq = s1_ff.vq;
      s2_in.c  = vs_prod[FRAC_BITS +: FRAC_W];
      priority if (hue_fold <= HUE_W'(SPAN)) begin
         s2_in.w = SPAN_W'(hue_fold);
      end else if (hue_fold <= HUE_W'(2*SPAN)) begin
         s2_in.w = SPAN_W'(HUE_W'(2*SPAN) - hue_fold);
      end else begin
         s2_in.w = '0;
      end

      s2_in.sector = SEC_GREY;
      for (int k = SECTORS - 1; k >= 0; k--) begin
         if (s1_ff.hue <= HUE_W'((k + 1) * SPAN)) begin
            s2_in.sector = SEC_W'(k);
         end
      end
      s2_in.sx  = s1_ff.sx;
      s2_in.sy  = s1_ff.sy;
      s2_in.vis = s1_ff.vis;
   end

   // Stage 3: chroma times weight, and the grey offset.
   always_comb begin
      s3_in.prod   = PROD_W'(s2_ff.c) * PROD_W'(s2_ff.w);
      s3_in.c      = s2_ff.c;
      s3_in.m      = s2_ff.vq - s2_ff.c;
      s3_in.sector = s2_ff.sector;
      s3_in.sx     = s2_ff.sx;
      s3_in.sy     = s2_ff.sy;
      s3_in.vis    = s2_ff.vis;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_vld_ff <= in_valid;
         if (s2_rdy) s2_vld_ff <= s1_vld_ff;
         if (s3_rdy) s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) s1_ff <= s1_in;
      if (s2_rdy) s2_ff <= s2_in;
      if (s3_rdy) s3_ff <= s3_in;
   end

   assign out_valid = s3_vld_ff;
   assign out_data  = s3_ff;

   a_chroma_le_value: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> (s2_ff.c <= s2_ff.vq))
      else $error("chroma exceeds value");

   a_weight_le_span: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> (32'(s2_ff.w) <= SPAN))
      else $error("sector weight exceeds span");

endmodule

`default_nettype wire

/* sv/hsvpg_xdiv.sv */
// Divide the chroma-weight product by the sector span: shift, reciprocal multiply, correct.
`default_nettype none

module hsvpg_xdiv (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  hsvpg_pkg::prod_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output hsvpg_pkg::mix_type  out_data
);
   import hsvpg_pkg::*;

   quo_type s4_in, s4_ff;
   mix_type s5_in, s5_ff;
   logic    s4_vld_ff, s5_vld_ff;
   logic    s4_rdy, s5_rdy;

   logic [FRAC_W-1:0] q0;
   logic [QUO_W-1:0]  rem;

   assign s5_rdy   = !s5_vld_ff || out_ready;
   assign s4_rdy   = !s4_vld_ff || s5_rdy;
   assign in_ready = s4_rdy;

   // Stage 4: drop the power-of-two part of the span, multiply by 1/15 estimate.
   always_comb begin
      s4_in.n      = in_data.prod[PROD_W-1:SPAN_SHIFT];
      s4_in.mul    = MUL_W'(s4_in.n) * MUL_W'(DIV15_MUL);
      s4_in.c      = in_data.c;
      s4_in.m      = in_data.m;
      s4_in.sector = in_data.sector;
      s4_in.sx     = in_data.sx;
      s4_in.sy     = in_data.sy;
      s4_in.vis    = in_data.vis;
   end

   // Stage 5: the estimate runs at most two low; fix it from the remainder.
   always_comb begin
      q0  = s4_ff.mul[DIV15_SHIFT +: FRAC_W];
      rem = s4_ff.n - QUO_W'(q0) * QUO_W'(DIV_ODD);
      s5_in.x      = q0 + FRAC_W'(rem >= QUO_W'(DIV_ODD)) +
                     FRAC_W'(rem >= QUO_W'(2*DIV_ODD));
      s5_in.c      = s4_ff.c;
      s5_in.m      = s4_ff.m;
      s5_in.sector = s4_ff.sector;
      s5_in.sx     = s4_ff.sx;
      s5_in.sy     = s4_ff.sy;
      s5_in.vis    = s4_ff.vis;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         if (s4_rdy) s4_vld_ff <= in_valid;
         if (s5_rdy) s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_rdy) s4_ff <= s4_in;
      if (s5_rdy) s5_ff <= s5_in;
   end

   assign out_valid = s5_vld_ff;
   assign out_data  = s5_ff;

   a_rem_bounded: assert property (@(posedge clock) disable iff (reset)
      s4_vld_ff |-> (rem < QUO_W'(DIV15_REM_MAX)))
      else $error("reciprocal estimate off by more than two");

   a_x_le_chroma: assert property (@(posedge clock) disable iff (reset)
      s5_vld_ff |-> (s5_ff.x <= s5_ff.c))
      else $error("secondary component exceeds chroma");

endmodule

`default_nettype wire

/* sv/hsv_plane_pixel_generator.sv */
// Top level of the HSV plane pixel generator: register file, pipeline and output stage.
//
//   channel   dir  beat carries                                      handshake
//   req_ch    in   row_index, column_index                           valid/ready
//   rsp_ch    out  screen_x, screen_y, red/green/blue_level, visible valid/ready
//   csr_ch    in   index (0 mode, 1 hue, 2 saturation, 3 value), data valid/ready
//
// Six register stages; one pixel beat enters per clock unless the pipeline is held.
// Sustained rate is one beat per clock, since every stage takes a new beat in each
// clock in which it is empty or being drained. Synchronous active-high reset clears
// the valid bits and loads mode 1 with zero hue, saturation and value. While a
// response waits with rsp_ch.ready low, each full stage with only full stages after
// it holds; empty stages still fill, so bubbles close up while the output waits.
// csr_ch is always ready; write registers only while the pipeline is empty.
`default_nettype none

module hsv_plane_pixel_generator (
   input  logic        clock,
   input  logic        reset,
   hsvpg_req_if.sink   req_ch,
   hsvpg_rsp_if.source rsp_ch,
   hsvpg_csr_if.sink   csr_ch
);
   import hsvpg_pkg::*;

   cfg_type  cfg;
   prod_type front_data;
   mix_type  mix_data;
   logic     front_valid, front_ready;
   logic     mix_valid, mix_ready;

   // Output stage: channel sums and level conversion.
   logic [FRAC_W-1:0] r_comp, g_comp, b_comp;
   logic [FRAC_W-1:0] r_sum, g_sum, b_sum;

   logic              rsp_vld_ff;
   logic [POS_W-1:0]  rsp_x_ff, rsp_y_ff;
   logic [LVL_W-1:0]  rsp_r_ff, rsp_g_ff, rsp_b_ff;
   logic              rsp_vis_ff;
   logic [LVL_W-1:0]  rsp_r_in, rsp_g_in, rsp_b_in;
   logic              out_rdy;

   hsvpg_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // Stages 1-3: plane decode, chroma and sector, chroma-weight product.
   hsvpg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_row    (req_ch.row_index),
      .in_col    (req_ch.column_index),
      .cfg       (cfg),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   // Stages 4-5: divide by the sector span to get the secondary component.
   hsvpg_xdiv u_xdiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (mix_valid),
      .out_ready (mix_ready),
      .out_data  (mix_data)
   );

   // Stage 6 advances when the response register is empty or being taken.
   assign out_rdy   = !rsp_vld_ff || rsp_ch.ready;
   assign mix_ready = out_rdy;

   // Route chroma and secondary component by sector; grey keeps only the offset.
   always_comb begin
      r_comp = '0;
      g_comp = '0;
      b_comp = '0;
      unique case (mix_data.sector)
         SEC_R_Y: begin r_comp = mix_data.c; g_comp = mix_data.x; end
         SEC_Y_G: begin r_comp = mix_data.x; g_comp = mix_data.c; end
         SEC_G_C: begin g_comp = mix_data.c; b_comp = mix_data.x; end
         SEC_C_B: begin g_comp = mix_data.x; b_comp = mix_data.c; end
         SEC_B_M: begin r_comp = mix_data.x; b_comp = mix_data.c; end
         SEC_M_R: begin r_comp = mix_data.c; b_comp = mix_data.x; end
         default: begin
            // hue past 360 degrees: grey
         end
      endcase
      // Sums stay at or below the value fraction, so they fit.
      r_sum    = r_comp + mix_data.m;
      g_sum    = g_comp + mix_data.m;
      b_sum    = b_comp + mix_data.m;
      rsp_r_in = to_level(r_sum);
      rsp_g_in = to_level(g_sum);
      rsp_b_in = to_level(b_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_vld_ff <= mix_valid;
      end
   end

   // Hold the response payload while the beat waits.
   always_ff @(posedge clock) begin
      if (out_rdy) begin
         rsp_x_ff   <= mix_data.sx;
         rsp_y_ff   <= mix_data.sy;
         rsp_r_ff   <= rsp_r_in;
         rsp_g_ff   <= rsp_g_in;
         rsp_b_ff   <= rsp_b_in;
         rsp_vis_ff <= mix_data.vis;
      end
   end

   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.screen_x    = rsp_x_ff;
   assign rsp_ch.screen_y    = rsp_y_ff;
   assign rsp_ch.red_level   = rsp_r_ff;
   assign rsp_ch.green_level = rsp_g_ff;
   assign rsp_ch.blue_level  = rsp_b_ff;
   assign rsp_ch.visible     = rsp_vis_ff;

   // A grey pixel has all three channels equal.
   a_grey_equal: assert property (@(posedge clock) disable iff (reset)
      (mix_valid && out_rdy && mix_data.sector == SEC_GREY) |=>
         (rsp_r_ff == rsp_g_ff) && (rsp_g_ff == rsp_b_ff))
      else $error("grey pixel with unequal channels");

endmodule

`default_nettype wire
